FILE: design/mhs_pkg.sv
// Shared constants, types and helpers for the MurmurHash2 string hash block.
`timescale 1ns / 1ps
`default_nettype none

package mhs_pkg;

    // Hash multiplier and the reset value of the seed register.
    localparam logic [31:0] MIX_MUL    = 32'h5bd1_e995;
    localparam logic [31:0] SEED_RESET = 32'hc70f_6907;

    // Shift amounts of the word mix and the final mix.
    localparam int unsigned WORD_SHIFT = 24;
    localparam int unsigned FIN_SHIFT1 = 13;
    localparam int unsigned FIN_SHIFT2 = 15;

    // Queue between the front and the back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // What an item contributes to the accumulator.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TAIL = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [31:0] init;   // seed XOR total length, used when first is set
        logic [31:0] data;   // mixed word or masked tail bytes
        logic [1:0]  kind;
        logic        first;
        logic        last;
    } mhs_entry_t;

    // Keeps the valid low bytes of a tail word (count of 1 to 3).
    function automatic logic [31:0] tail_mask(input logic [1:0] count);
        logic [31:0] mask;
        unique case (count)
            2'd1:    mask = 32'h0000_00ff;
            2'd2:    mask = 32'h0000_ffff;
            2'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

FILE: design/mhs_front.sv
// Front end: accepts items, classifies them and premixes full words in two stages.
`timescale 1ns / 1ps
`default_nettype none

module mhs_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [31:0]         seed,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         data_word,
    input  wire logic [2:0]          byte_count,
    input  wire logic                first,
    input  wire logic                last,
    input  wire logic [31:0]         total_length,
    output logic                     q_push,
    output mhs_pkg::mhs_entry_t      q_entry,
    input  wire logic                q_full
);
    import mhs_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_k1_reg;
    logic [31:0] s1_tail_reg;
    logic [31:0] s1_init_reg;
    logic [1:0]  s1_kind_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;

    logic        s2_valid_reg;
    logic        s2_valid_next;
    mhs_entry_t  s2_entry_reg;
    mhs_entry_t  s2_entry_next;

    logic        accept;
    logic        s1_adv;
    logic        s2_adv;
    logic [1:0]  kind_in;
    logic [31:0] k1_xs;
    logic [31:0] k2;

    // Pipeline flow control: each stage moves when the one after it has room.
    always_comb
    begin
        s2_adv   = s2_valid_reg && !q_full;
        s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
        in_ready = !s1_valid_reg || s1_adv;
        accept   = in_valid && in_ready;
    end

    // Classify by byte count; counts above four behave as four.
    always_comb
    begin
        priority if (byte_count[2])
        begin
            kind_in = KIND_FULL;
        end
        else if (byte_count[1:0] == 2'd0)
        begin
            kind_in = KIND_NONE;
        end
        else
        begin
            kind_in = KIND_TAIL;
        end
    end

    // Second multiply of the word mix and the queue entry it feeds.
    always_comb
    begin
        k1_xs              = s1_k1_reg ^ (s1_k1_reg >> WORD_SHIFT);
        k2                 = k1_xs * MIX_MUL;
        s2_entry_next.init  = s1_init_reg;
        s2_entry_next.data  = (s1_kind_reg == KIND_FULL) ? k2 : s1_tail_reg;
        s2_entry_next.kind  = s1_kind_reg;
        s2_entry_next.first = s1_first_reg;
        s2_entry_next.last  = s1_last_reg;
    end

    always_comb
    begin
        s1_valid_next = accept || (s1_valid_reg && !s1_adv);
        s2_valid_next = s1_adv || (s2_valid_reg && !s2_adv);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage one payload: first multiply, tail masking, initial hash value.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_k1_reg    <= data_word * MIX_MUL;
            s1_tail_reg  <= data_word & tail_mask(byte_count[1:0]);
            s1_init_reg  <= seed ^ total_length;
            s1_kind_reg  <= kind_in;
            s1_first_reg <= first;
            s1_last_reg  <= last;
        end
    end

    // Stage two payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_entry_reg <= s2_entry_next;
        end
    end

    assign q_push  = s2_valid_reg;
    assign q_entry = s2_entry_reg;

endmodule

`default_nettype wire

FILE: design/mhs_queue.sv
// Short register queue that decouples the front end from the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module mhs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire mhs_pkg::mhs_entry_t push_entry,
    output logic                     full,
    input  wire logic                pop,
    output mhs_pkg::mhs_entry_t      head,
    output logic                     empty
);
    import mhs_pkg::*;

    localparam int unsigned CW = $clog2(Q_DEPTH + 1);

    mhs_entry_t      slots_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        full    = (count_reg == CW'(Q_DEPTH));
        empty   = (count_reg == '0);
        do_push = push && !full;
        do_pop  = pop && !empty;
        head    = slots_reg[rd_ptr_reg];
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: design/mhs_back.sv
// Back end: folds queued items into the accumulator and runs the final mix.
`timescale 1ns / 1ps
`default_nettype none

module mhs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mhs_pkg::mhs_entry_t head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [31:0]              hash
);
    import mhs_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FIN1 = 2'd1;
    localparam logic [1:0] ST_FIN2 = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] fin_reg;
    logic [31:0] fin_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    logic [31:0] h_base;
    logic [31:0] h_fold;
    logic [31:0] fin_xs;
    logic        out_free;

    // Accumulator fold of the item at the head of the queue.
    always_comb
    begin
        h_base = head.first ? head.init : acc_reg;
        unique case (head.kind)
            KIND_FULL: h_fold = (h_base * MIX_MUL) ^ head.data;
            KIND_TAIL: h_fold = (h_base ^ head.data) * MIX_MUL;
            default:   h_fold = h_base;
        endcase
    end

    // Sequencer: one fold per cycle in ST_RUN, then ST_FIN1 and ST_FIN2.
    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        fin_xs         = acc_reg ^ (acc_reg >> FIN_SHIFT1);
        state_next     = state_reg;
        acc_next       = acc_reg;
        fin_next       = fin_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    acc_next = h_fold;
                    if (head.last)
                    begin
                        state_next = ST_FIN1;
                    end
                end
            end
            ST_FIN1:
            begin
                fin_next   = fin_xs * MIX_MUL;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                if (out_free)
                begin
                    hash_next      = fin_reg ^ (fin_reg >> FIN_SHIFT2);
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Final mix and result payload.
    always_ff @(posedge clk)
    begin
        fin_reg  <= fin_next;
        hash_reg <= hash_next;
    end

    assign out_valid = out_valid_reg;
    assign hash      = hash_reg;

endmodule

`default_nettype wire

FILE: design/murmur2_string_hash_top.sv
// Top level of the streaming 32-bit MurmurHash2 string hash.
//
//  Channel   Direction  Contents
//  s_axis    in         string words; tdata, tlast = last, tuser = first
//  m_axis    out        one hash per string, sent on the last item
//  cfg       in         seed register write, reset value 0xc70f6907
//
// The input takes one item per cycle while the front pipeline and queue have room.
// An item passes through the front pipeline stages s1 and s2 and then the queue; the
// back end folds one item per cycle while it is not running the final mix.
// A last item then runs the final mix before its hash enters the output register.
// Reset clears the pipeline, queue, accumulator and output; no clearing pass is needed.
// A stalled output holds the back end at its next last item, and the queue then fills
// before the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_string_hash_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // data_word [31:0], byte_count [34:32], total_length [66:35], zero [71:67]
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // first [0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // hash [31:0]
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);
    import mhs_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    mhs_entry_t  q_in;
    mhs_entry_t  q_head;

    // Seed register.
    assign seed_next = cfg_wr_en ? cfg_wr_data : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mhs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed         (seed_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .data_word    (s_axis_tdata[31:0]),
        .byte_count   (s_axis_tdata[34:32]),
        .first        (s_axis_tuser[0]),
        .last         (s_axis_tlast),
        .total_length (s_axis_tdata[66:35]),
        .q_push       (q_push),
        .q_entry      (q_in),
        .q_full       (q_full)
    );

    mhs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    mhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .hash      (m_axis_tdata)
    );

endmodule

`default_nettype wire
